[rtl/snwt_pkg.sv]
// ----------------------------------------------------------------------------
// snwt_pkg
// shared types, constants and helpers of the scene node world transform core
// ----------------------------------------------------------------------------
package snwt_pkg;

    localparam int SNWT_MAX_NODES = 1024;

    localparam int IN_DATA_W  = 344;
    localparam int OUT_DATA_W = 144;

    localparam logic [3:0] LOAD_LAST  = 4'd11;
    localparam logic [3:0] QUAT_LAST  = 4'd2;
    localparam logic [3:0] LOCAL_LAST = 4'd2;
    localparam logic [3:0] WORLD_LAST = 4'd11;
    localparam logic [1:0] ROW_LAST   = 2'd3;

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_QUAT,
        ST_ROT,
        ST_ROT_WAIT,
        ST_LOCAL,
        ST_LOCAL_WAIT,
        ST_WORLD,
        ST_WORLD_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_QUAT,
        OP_ROT,
        OP_LOCAL,
        OP_WORLD
    } t_op;

    typedef struct packed {
        logic       capture;
        t_op        op;
        logic [3:0] idx;
        logic [1:0] row;
    } t_dp_cmd;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -68'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

[rtl/snwt_ctrl.sv]
// ----------------------------------------------------------------------------
// snwt_ctrl
// sequencer: parent load, rotation, local and world phases, row emission
// ----------------------------------------------------------------------------
module snwt_ctrl
    import snwt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  logic    i_m_ready,
    output logic    o_s_ready,
    output logic    o_m_valid,
    output logic    o_m_last,
    output t_dp_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    n_state = ST_LOAD;
                    n_cnt   = '0;
                end
            end
            ST_LOAD: begin
                if (r_cnt == LOAD_LAST) begin
                    n_state = ST_QUAT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_QUAT: begin
                if (r_cnt == QUAT_LAST) begin
                    n_state = ST_ROT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_ROT:      n_state = ST_ROT_WAIT;
            ST_ROT_WAIT: begin
                n_state = ST_LOCAL;
                n_cnt   = '0;
            end
            ST_LOCAL: begin
                if (r_cnt == LOCAL_LAST) begin
                    n_state = ST_LOCAL_WAIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_LOCAL_WAIT: begin
                n_state = ST_WORLD;
                n_cnt   = '0;
            end
            ST_WORLD: begin
                if (r_cnt == WORLD_LAST) begin
                    n_state = ST_WORLD_WAIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_WORLD_WAIT: begin
                n_state = ST_EMIT;
                n_cnt   = '0;
            end
            ST_EMIT: begin
                if (i_m_ready) begin
                    if (r_cnt[1:0] == ROW_LAST) begin
                        n_state = ST_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        o_s_ready     = 1'b0;
        o_m_valid     = 1'b0;
        o_m_last      = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.op      = OP_NONE;
        o_cmd.idx     = r_cnt;
        o_cmd.row     = r_cnt[1:0];
        case (r_state)
            ST_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.capture = i_s_valid;
            end
            ST_LOAD:  o_cmd.op = OP_LOAD;
            ST_QUAT:  o_cmd.op = OP_QUAT;
            ST_ROT:   o_cmd.op = OP_ROT;
            ST_LOCAL: o_cmd.op = OP_LOCAL;
            ST_WORLD: o_cmd.op = OP_WORLD;
            ST_EMIT: begin
                o_m_valid = 1'b1;
                o_m_last  = (r_cnt[1:0] == ROW_LAST);
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

[rtl/snwt_datapath.sv]
// ----------------------------------------------------------------------------
// snwt_datapath
// three shared multipliers, matrix registers and the world matrix memory
// ----------------------------------------------------------------------------
module snwt_datapath
    import snwt_pkg::*;
#(
    parameter int MAX_NODES = SNWT_MAX_NODES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [IN_DATA_W-1:0]  i_data,
    output logic [OUT_DATA_W-1:0] o_data
);

    localparam int SW = $clog2(MAX_NODES);
    localparam int MEM_DEPTH = MAX_NODES * 12;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int SHR = 10 + $clog2(MAX_NODES);
    localparam logic [31:0] RECIP =
        32'(((64'd1 << SHR) + 64'(MAX_NODES) - 64'd1) / 64'(MAX_NODES));
    localparam logic [31:0] MODV = 32'(MAX_NODES);
    localparam logic [AW-1:0] WPN = AW'(12);
    localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

    // raw mod MAX_NODES by reciprocal multiplication, exact for a 10-bit raw slot
    function automatic logic [SW-1:0] slot_of(input logic [9:0] raw);
        logic [31:0] quo;
        logic [31:0] rem;
        quo = (32'(raw) * RECIP) >> SHR;
        rem = 32'(raw) - quo * MODV;
        return rem[SW-1:0];
    endfunction

    function automatic logic [3:0] idx3(input logic [1:0] r, input int k);
        return 4'({2'b00, r} * 4'd3) + 4'(k);
    endfunction

    // captured item
    logic [9:0]        r_node_raw;
    logic [SW-1:0]     r_node_slot, r_par_slot;
    logic              r_root;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_sc  [3];
    logic signed [31:0] r_qw, r_qx, r_qy, r_qz;

    // working matrices
    logic signed [31:0] r_par [12];
    logic signed [33:0] r_q   [9];
    logic signed [31:0] r_rot [9];
    logic signed [31:0] r_loc [9];
    logic signed [31:0] r_wld [12];
    logic signed [63:0] r_p   [3];

    logic [31:0] r_mem [MEM_DEPTH];
    logic [31:0] r_rd;

    t_op        r_op_d;
    logic [3:0] r_idx_d;

    logic signed [31:0] op_a [3];
    logic signed [31:0] op_b [3];
    logic signed [35:0] rot_raw [9];
    logic signed [67:0] wsum;
    logic signed [31:0] w_val;
    logic [1:0]         wr_r, wr_c, rd_r, rd_c;
    logic [AW-1:0]      rd_addr, wr_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_node_raw  <= i_data[9:0];
            r_node_slot <= slot_of(i_data[9:0]);
            r_par_slot  <= slot_of(i_data[19:10]);
            r_root      <= (i_data[9:0] == i_data[19:10]);
            r_pos[0]    <= i_data[51:20];
            r_pos[1]    <= i_data[83:52];
            r_pos[2]    <= i_data[115:84];
            r_qw        <= i_data[147:116];
            r_qx        <= i_data[179:148];
            r_qy        <= i_data[211:180];
            r_qz        <= i_data[243:212];
            r_sc[0]     <= i_data[275:244];
            r_sc[1]     <= i_data[307:276];
            r_sc[2]     <= i_data[339:308];
        end
    end

    // stage one: operand select and multiply
    assign rd_r = i_cmd.idx[3:2];
    assign rd_c = i_cmd.idx[1:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            op_a[k] = '0;
            op_b[k] = '0;
        end
        case (i_cmd.op)
            OP_QUAT: begin
                case (i_cmd.idx[1:0])
                    2'd0: begin
                        op_a[0] = r_qx; op_b[0] = r_qx;
                        op_a[1] = r_qy; op_b[1] = r_qy;
                        op_a[2] = r_qz; op_b[2] = r_qz;
                    end
                    2'd1: begin
                        op_a[0] = r_qx; op_b[0] = r_qy;
                        op_a[1] = r_qx; op_b[1] = r_qz;
                        op_a[2] = r_qy; op_b[2] = r_qz;
                    end
                    default: begin
                        op_a[0] = r_qw; op_b[0] = r_qx;
                        op_a[1] = r_qw; op_b[1] = r_qy;
                        op_a[2] = r_qw; op_b[2] = r_qz;
                    end
                endcase
            end
            OP_LOCAL: begin
                for (int k = 0; k < 3; k++) begin
                    op_a[k] = r_rot[idx3(i_cmd.idx[1:0], k)];
                    op_b[k] = r_sc[k];
                end
            end
            OP_WORLD: begin
                for (int k = 0; k < 3; k++) begin
                    op_a[k] = r_par[{rd_r, 2'(k)}];
                    op_b[k] = (rd_c == 2'd3) ? r_pos[k] : r_loc[idx3(2'(k), int'(rd_c))];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_p[k] <= op_a[k] * op_b[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_d  <= OP_NONE;
            r_idx_d <= '0;
        end else begin
            r_op_d  <= i_cmd.op;
            r_idx_d <= i_cmd.idx;
        end
    end

    // parent rows, one word a transaction of the memory
    assign rd_addr = AW'(r_par_slot) * WPN + AW'(i_cmd.idx);
    assign wr_addr = AW'(r_node_slot) * WPN + AW'(r_idx_d);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_op_d == OP_WORLD) begin
            r_mem[wr_addr] <= w_val;
        end
    end

    // rotation matrix from the floored quaternion products
    // r_q: xx yy zz xy xz yz wx wy wz
    always_comb begin
        rot_raw[0] = ONE_Q30 - 36'sd2 * (36'(r_q[1]) + 36'(r_q[2]));
        rot_raw[1] = 36'sd2 * (36'(r_q[3]) - 36'(r_q[8]));
        rot_raw[2] = 36'sd2 * (36'(r_q[4]) + 36'(r_q[7]));
        rot_raw[3] = 36'sd2 * (36'(r_q[3]) + 36'(r_q[8]));
        rot_raw[4] = ONE_Q30 - 36'sd2 * (36'(r_q[0]) + 36'(r_q[2]));
        rot_raw[5] = 36'sd2 * (36'(r_q[5]) - 36'(r_q[6]));
        rot_raw[6] = 36'sd2 * (36'(r_q[4]) - 36'(r_q[7]));
        rot_raw[7] = 36'sd2 * (36'(r_q[5]) + 36'(r_q[6]));
        rot_raw[8] = ONE_Q30 - 36'sd2 * (36'(r_q[0]) + 36'(r_q[1]));
    end

    // world entry: three exact products (+ parent offset in col 3), floored once
    assign wr_r = r_idx_d[3:2];
    assign wr_c = r_idx_d[1:0];

    always_comb begin
        wsum = 68'(r_p[0]) + 68'(r_p[1]) + 68'(r_p[2]);
        if (wr_c == 2'd3) begin
            wsum = wsum + (68'(r_par[{wr_r, 2'd3}]) <<< 16);
        end
        if (r_root) begin
            w_val = (wr_c == 2'd3) ? r_pos[wr_r] : r_loc[idx3(wr_r, int'(wr_c))];
        end else begin
            w_val = sat32(wsum >>> 16);
        end
    end

    // stage two: write back
    always_ff @(posedge i_clk) begin
        case (r_op_d)
            OP_LOAD: r_par[r_idx_d] <= r_rd;
            OP_QUAT: begin
                for (int k = 0; k < 3; k++) begin
                    r_q[idx3(r_idx_d[1:0], k)] <= 34'(r_p[k] >>> 30);
                end
            end
            OP_ROT: begin
                for (int i = 0; i < 9; i++) begin
                    r_rot[i] <= sat32(68'(rot_raw[i]));
                end
            end
            OP_LOCAL: begin
                for (int k = 0; k < 3; k++) begin
                    r_loc[idx3(r_idx_d[1:0], k)] <= sat32(68'(r_p[k] >>> 30));
                end
            end
            OP_WORLD: r_wld[r_idx_d] <= w_val;
            default: ;
        endcase
    end

    // output row
    always_comb begin
        if (i_cmd.row == ROW_LAST) begin
            o_data = {4'b0, ONE_Q16, 32'sd0, 32'sd0, 32'sd0, i_cmd.row, r_node_raw};
        end else begin
            o_data = {4'b0, r_wld[{i_cmd.row, 2'd3}], r_wld[{i_cmd.row, 2'd2}],
                      r_wld[{i_cmd.row, 2'd1}], r_wld[{i_cmd.row, 2'd0}],
                      i_cmd.row, r_node_raw};
        end
    end

endmodule

[rtl/scene_node_world_transform_core.sv]
// ----------------------------------------------------------------------------
// scene_node_world_transform_core
// world matrix of a scene node from position, rotation quaternion and scale
// ----------------------------------------------------------------------------
// output: rows follow the load, quaternion, rotation, local and world phases and
//   go out one a cycle while the sink is ready; a new node is taken only once
//   the last row of the one before is out; each node takes the twelve-word parent
//   read from the single memory port and three shared multipliers over 3 + 3 + 12 steps
// reset: synchronous active low, clears the sequencer; the matrix memory is
//   not cleared, a parent must be sent before its children
module scene_node_world_transform_core
    import snwt_pkg::*;
#(
    parameter int MAX_NODES = SNWT_MAX_NODES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // node_index, parent_index, pos_x, pos_y, pos_z, rot_w, rot_x, rot_y,
    // rot_z, scale_x, scale_y, scale_z (lowest bit up), 4 pad bits
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // master side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_node, row_number, col0, col1, col2, col3 (lowest bit up), 4 pad bits
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // last_row
    output logic                  o_m_axis_tlast
);

    // command path from sequencer to datapath
    t_dp_cmd cmd;

    // sequencer walks load, quaternion, rotation, local, world and emit phases
    snwt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_m_last  (o_m_axis_tlast),
        .o_cmd     (cmd)
    );

    // multipliers, matrix registers and world matrix memory
    snwt_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_data  (i_s_axis_tdata),
        .o_data  (o_m_axis_tdata)
    );

endmodule

[rtl/snwt_checker.sv]
// ----------------------------------------------------------------------------
// snwt_checker
// port level checks of the world transform core
// ----------------------------------------------------------------------------
module snwt_checker
    import snwt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tlast
);

    // stalled row holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("row changed while stalled");

    // one node in flight
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while rows pending");

    // tlast marks row three
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[11:10] == ROW_LAST)))
        else $error("tlast does not match row");

    // bottom row is 0 0 0 1
    a_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[11:10] == ROW_LAST |->
        o_m_axis_tdata[43:12] == '0 && o_m_axis_tdata[75:44] == '0 &&
        o_m_axis_tdata[107:76] == '0 && o_m_axis_tdata[139:108] == ONE_Q16)
        else $error("bad bottom row");

    // first row comes only after processing
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_m_axis_tvalid)
        else $error("row too early");

endmodule

bind scene_node_world_transform_core snwt_checker u_snwt_checker (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// testbench of the scene node world transform core: nodes go in parents
// first, each accepted node is run through a local predictor of the world
// matrix, and the four emitted rows are checked against it field by field
// ----------------------------------------------------------------------------
module tb;
    import snwt_pkg::*;

    localparam int NODE_SLOTS = SNWT_MAX_NODES;
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam int Q30_ONE_I = 32'sd1073741824;

    // one scene node as it is offered to the core
    typedef struct {
        logic [9:0]         node;
        logic [9:0]         parent;
        logic signed [31:0] pos [3];
        logic signed [31:0] quat [4];   // w, x, y, z
        logic signed [31:0] scl [3];
        bit                 drain_first;
    } t_node_item;

    // one world matrix row as the core returns it
    typedef struct {
        logic [9:0]         node;
        logic [1:0]         row;
        logic signed [31:0] col [4];
        logic               last;
    } t_matrix_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    t_node_item  nodes_to_send [$];
    t_matrix_row rows_due [$];
    // world matrices rows 0..2 as the predictor sees them
    longint      world_store [NODE_SLOTS][12];
    bit          slot_built [NODE_SLOTS];

    int  mismatches = 0;
    int  nodes_accepted = 0;
    int  rows_checked = 0;
    int  roots_sent = 0;
    bit  stim_done = 0;
    bit  last_taken = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;

    scene_node_world_transform_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // pack fields from the lowest bit up, pad bits zero
    function automatic logic [IN_DATA_W-1:0] pack_node(t_node_item it);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[9:0]   = it.node;
        d[19:10] = it.parent;
        for (int k = 0; k < 3; k++) d[20 + 32*k +: 32] = it.pos[k];
        for (int k = 0; k < 4; k++) d[116 + 32*k +: 32] = it.quat[k];
        for (int k = 0; k < 3; k++) d[244 + 32*k +: 32] = it.scl[k];
        return d;
    endfunction

    // world matrix of one accepted node; updates the store, queues four rows
    task automatic predict_world_rows(t_node_item it);
        longint w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint rot [3][3];
        longint loc [3][4];
        longint wld [3][4];
        longint hi, lo, p;
        t_matrix_row mr;
        int slot_p, slot_n;
        w = it.quat[0]; x = it.quat[1]; y = it.quat[2]; z = it.quat[3];
        // quaternion products floored to q.30 before the sums
        xx = (x * x) >>> 30; yy = (y * y) >>> 30; zz = (z * z) >>> 30;
        xy = (x * y) >>> 30; xz = (x * z) >>> 30; yz = (y * z) >>> 30;
        wx = (w * x) >>> 30; wy = (w * y) >>> 30; wz = (w * z) >>> 30;
        rot[0][0] = Q30_ONE - 2 * (yy + zz);
        rot[0][1] = 2 * (xy - wz);
        rot[0][2] = 2 * (xz + wy);
        rot[1][0] = 2 * (xy + wz);
        rot[1][1] = Q30_ONE - 2 * (xx + zz);
        rot[1][2] = 2 * (yz - wx);
        rot[2][0] = 2 * (xz - wy);
        rot[2][1] = 2 * (yz + wx);
        rot[2][2] = Q30_ONE - 2 * (xx + yy);
        // local = t * r * s
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                loc[r][c] = clip32((clip32(rot[r][c]) * longint'(it.scl[c])) >>> 30);
            end
            loc[r][3] = it.pos[r];
        end
        slot_p = it.parent % NODE_SLOTS;
        slot_n = it.node % NODE_SLOTS;
        if (it.node == it.parent) begin
            wld = loc;
        end else begin
            // exact sum of q32.32 products, floored once to q16.16
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    hi = (c == 3) ? world_store[slot_p][r*4 + 3] : 0;
                    lo = 0;
                    for (int k = 0; k < 3; k++) begin
                        p = world_store[slot_p][r*4 + k] * loc[k][c];
                        hi += p >>> 16;
                        lo += p & 64'hffff;
                    end
                    wld[r][c] = clip32(hi + (lo >>> 16));
                end
            end
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) world_store[slot_n][r*4 + c] = wld[r][c];
        end
        for (int r = 0; r < 4; r++) begin
            mr.node = it.node;
            mr.row  = r[1:0];
            for (int c = 0; c < 4; c++) begin
                mr.col[c] = (r < 3) ? wld[r][c][31:0] : ((c == 3) ? ONE_Q16 : 32'sd0);
            end
            mr.last = (r == 3);
            rows_due.push_back(mr);
        end
    endtask

    // queue one node for the driver, tracking which slots already hold a matrix
    task automatic add_node(int nd, int pa, int px, int py, int pz, int qw, int qx,
                            int qy, int qz, int sx, int sy, int sz, bit drain);
        t_node_item it;
        it.node = nd[9:0];
        it.parent = pa[9:0];
        it.pos[0] = px; it.pos[1] = py; it.pos[2] = pz;
        it.quat[0] = qw; it.quat[1] = qx; it.quat[2] = qy; it.quat[3] = qz;
        it.scl[0] = sx; it.scl[1] = sy; it.scl[2] = sz;
        it.drain_first = drain;
        slot_built[nd] = 1'b1;
        if (nd == pa) roots_sent++;
        nodes_to_send.push_back(it);
    endtask

    function automatic int rand_q16();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return int'($urandom_range(0, 20'hfffff)) - 32'sh80000;
        endcase
    endfunction

    function automatic int rand_quat_part();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? Q30_ONE_I : -Q30_ONE_I;
            1:       return 0;
            default: return int'($urandom_range(0, 32'h80000000)) - Q30_ONE_I;
        endcase
    endfunction

    // stimulus: directed corner nodes, then random parent-first trees
    initial begin
        int nd, pa, picks;
        int built [$];
        int half;
        half = 32'sd536870912;
        // roots with extreme fields and every pure axis rotation
        add_node(0, 0, 0, 0, 0, Q30_ONE_I, 0, 0, 0, 65536, 65536, 65536, 0);
        add_node(1, 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, -Q30_ONE_I, 0, 0, 0,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
        add_node(2, 2, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, Q30_ONE_I, 0, 0,
                 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        add_node(3, 3, -1, 1, 65536, 0, 0, -Q30_ONE_I, 0, -65536, -65536, -65536, 0);
        add_node(1023, 1023, 123456, -98765, 7, 0, 0, 0, Q30_ONE_I, 131072, 32768, 65536, 0);
        // non-unit quaternions whose entries saturate, then a unit one with uneven scale
        add_node(4, 4, 0, 0, 0, Q30_ONE_I, Q30_ONE_I, Q30_ONE_I, Q30_ONE_I,
                 32'sh7fffffff, 32'sh80000000, 65536, 0);
        add_node(5, 5, 1000, 2000, 3000, -Q30_ONE_I, -Q30_ONE_I, -Q30_ONE_I, -Q30_ONE_I,
                 65536, 65536, 65536, 0);
        add_node(6, 6, 65536, 0, -65536, half, half, half, half, 65536, 131072, 196608, 0);
        // children, including ones that saturate through a large parent
        add_node(7, 0, 65536, 131072, -65536, half, -half, half, -half, 65536, 65536, 65536, 0);
        add_node(8, 1, 32'sh7fffffff, 32'sh80000000, 1, Q30_ONE_I, 0, 0, 0,
                 32'sh7fffffff, 65536, 32'sh80000000, 0);
        add_node(9, 2, -1, -1, -1, 0, Q30_ONE_I, 0, 0, 65536, 65536, 65536, 0);
        add_node(10, 1023, 500000, 0, -500000, 0, 0, Q30_ONE_I, 0, 65536, 65536, 65536, 0);
        add_node(11, 4, 1, 2, 3, Q30_ONE_I, 0, 0, 0, 65536, 65536, 65536, 0);
        add_node(12, 11, 65536, 65536, 65536, half, half, -half, half, 32768, 32768, 32768, 0);
        add_node(1022, 12, -7, 7, -7, 0, 0, 0, -Q30_ONE_I, 65536, -65536, 65536, 0);
        // an existing slot is overwritten by a child, then used as a parent
        add_node(0, 5, 65536, 0, 0, Q30_ONE_I, 0, 0, 0, 65536, 65536, 65536, 0);
        add_node(13, 0, 0, 65536, 0, half, half, half, half, 65536, 65536, 65536, 0);
        add_node(14, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < NODE_SLOTS; i++) if (slot_built[i]) built.push_back(i);
        // random part, mostly children of built slots with random content
        for (int i = 0; i < 392; i++) begin
            nd = $urandom_range(0, NODE_SLOTS - 1);
            picks = $urandom_range(0, 9);
            if (picks < 2 || built.size() == 0) begin
                pa = nd;
            end else if (picks < 4) begin
                pa = built[built.size() - 1 - $urandom_range(0, built.size() > 8 ? 7 : 0)];
            end else begin
                pa = built[$urandom_range(0, built.size() - 1)];
            end
            if (pa == nd && picks >= 2) pa = nd; // child may not alias itself; becomes a root
            if (!slot_built[nd]) built.push_back(nd);
            if ($urandom_range(0, 2) == 0) begin
                add_node(nd, pa, rand_q16(), rand_q16(), rand_q16(),
                         rand_quat_part(), rand_quat_part(), rand_quat_part(),
                         rand_quat_part(), rand_q16(), rand_q16(), rand_q16(), i == 200);
            end else begin
                // near-unit scale keeps matrices well away from saturation
                add_node(nd, pa, int'($urandom_range(0, 32'hffffff)) - 32'sh800000,
                         int'($urandom_range(0, 32'hffffff)) - 32'sh800000,
                         int'($urandom_range(0, 32'hffffff)) - 32'sh800000,
                         rand_quat_part(), rand_quat_part(), rand_quat_part(),
                         rand_quat_part(), int'($urandom_range(32768, 98304)),
                         int'($urandom_range(32768, 98304)),
                         int'($urandom_range(0, 131072)) - 65536, i == 200);
            end
        end
        stim_done = 1'b1;
    end

    // reset once, then wait for every node to be taken and every row returned
    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stim_done && nodes_to_send.size() == 0 && rows_due.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("run covered %0d nodes (%0d roots), %0d rows checked, %0d mismatches",
                 nodes_accepted, roots_sent, rows_checked, mismatches);
        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // overall limit, far above the slowest legal run
    initial begin
        #4000000;
        $display("timeout: %0d rows still due", rows_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // input transaction seen at the rising edge: predict and drop it from the queue
    always @(posedge i_clk) begin
        last_taken <= (i_rst_n && i_s_axis_tvalid && o_s_axis_tready);
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            predict_world_rows(nodes_to_send.pop_front());
            nodes_accepted++;
        end
    end

    // driver: bursts and gaps, holds an offer until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else if (!i_s_axis_tvalid || last_taken) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 30);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            end
            if (gap_left > 0 && burst_left == 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (nodes_to_send.size() != 0 &&
                         !(nodes_to_send[0].drain_first && rows_due.size() != 0)) begin
                burst_left--;
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= pack_node(nodes_to_send[0]);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stall pattern plus one long hold-off that backs up the core
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (!hold_done && nodes_accepted >= 120) begin
                hold_done = 1'b1;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if ((nodes_accepted / 50) % 2 == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    // monitor: compare each output transaction with the oldest predicted row
    always @(posedge i_clk) begin
        t_matrix_row want, got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.node = o_m_axis_tdata[9:0];
            got.row  = o_m_axis_tdata[11:10];
            for (int c = 0; c < 4; c++) got.col[c] = o_m_axis_tdata[12 + 32*c +: 32];
            got.last = o_m_axis_tlast;
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected row: node %0d row %0d",
                                               got.node, got.row);
            end else begin
                want = rows_due.pop_front();
                rows_checked++;
                if (got.node !== want.node || got.row !== want.row ||
                    got.last !== want.last || got.col[0] !== want.col[0] ||
                    got.col[1] !== want.col[1] || got.col[2] !== want.col[2] ||
                    got.col[3] !== want.col[3]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("row mismatch: exp node %0d row %0d last %0d %h %h %h %h",
                                 want.node, want.row, want.last, want.col[0],
                                 want.col[1], want.col[2], want.col[3]);
                        $display("              got node %0d row %0d last %0d %h %h %h %h",
                                 got.node, got.row, got.last, got.col[0],
                                 got.col[1], got.col[2], got.col[3]);
                    end
                end
            end
        end
    end

endmodule

[sim.f]
rtl/snwt_pkg.sv
rtl/snwt_ctrl.sv
rtl/snwt_datapath.sv
rtl/scene_node_world_transform_core.sv
rtl/snwt_checker.sv
test/tb.sv
